@@ hw/rtl/stf_pkg.sv @@
// Package for the strip/fan to triangle list converter: constants, types and helpers.
package stf_pkg;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned INDEX_BITS  = 16;
  localparam int unsigned OUT_IDX_W   = 16;
  localparam int unsigned COUNT_W     = 31;

  localparam logic [1:0] REC_LAST_WORD = 2'd2;

  localparam logic [1:0] SEEN_NONE  = 2'd0;
  localparam logic [1:0] SEEN_ONE   = 2'd1;
  localparam logic [1:0] SEEN_TWO   = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef logic [OUT_IDX_W-1:0] idx_t;

  typedef struct packed {
    logic end_of_list;
    idx_t index_a;
    idx_t index_b;
    idx_t index_c;
  } tri_t;

  typedef struct packed {
    logic emit;
    tri_t data;
  } res_t;

  // Low INDEX_BITS of the word, kept to the output index width.
  function automatic idx_t take_index(input logic [WORD_BITS-1:0] w);
    idx_t r;
    r = '0;
    for (int i = 0; i < int'(OUT_IDX_W); i++) begin
      if (i < int'(INDEX_BITS)) begin
        r[i] = w[i];
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/stf_word_if.sv @@
// Input channel interface: one stream word per item.
interface stf_word_if;
  logic                              valid;
  logic                              ready;
  logic signed [stf_pkg::WORD_BITS-1:0] word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

@@ hw/rtl/stf_tri_if.sv @@
// Result channel interface: one triangle or end marker per item.
interface stf_tri_if;
  logic          valid;
  logic          ready;
  logic          end_of_list;
  stf_pkg::idx_t index_a;
  stf_pkg::idx_t index_b;
  stf_pkg::idx_t index_c;

  modport source (output valid, output end_of_list, output index_a, output index_b,
                  output index_c, input ready);
  modport sink   (input valid, input end_of_list, input index_a, input index_b,
                  input index_c, output ready);
endinterface

@@ hw/rtl/stf_ctrl.sv @@
// Command/record parser state and triangle assembly for each accepted item.
module stf_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [stf_pkg::WORD_BITS-1:0] word,
  output stf_pkg::res_t                 res
);

  logic                         in_prim_r, in_prim_nxt;
  logic                         fan_r, fan_nxt;
  logic [stf_pkg::COUNT_W-1:0]  left_r, left_nxt;
  logic [1:0]                   wir_r, wir_nxt;
  logic [1:0]                   seen_r, seen_nxt;
  stf_pkg::idx_t                anchor_r, anchor_nxt;
  stf_pkg::idx_t                recent_r, recent_nxt;

  logic [stf_pkg::WORD_BITS-1:0] mag;
  logic [stf_pkg::COUNT_W-1:0]   left_dec;
  stf_pkg::idx_t                 idx;

  always_comb begin
    in_prim_nxt = in_prim_r;
    fan_nxt     = fan_r;
    left_nxt    = left_r;
    wir_nxt     = wir_r;
    seen_nxt    = seen_r;
    anchor_nxt  = anchor_r;
    recent_nxt  = recent_r;
    res         = '0;
    mag         = ~word + {{(stf_pkg::WORD_BITS-1){1'b0}}, 1'b1};
    left_dec    = (left_r != '0) ? left_r - {{(stf_pkg::COUNT_W-1){1'b0}}, 1'b1} : '0;
    idx         = stf_pkg::take_index(word);
    if (accept) begin
      if (!in_prim_r) begin
        if (word == '0) begin
          res.emit             = 1'b1;
          res.data.end_of_list = 1'b1;
        end else begin
          if (word[stf_pkg::WORD_BITS-1]) begin
            fan_nxt  = 1'b1;
            left_nxt = mag[stf_pkg::WORD_BITS-1] ? stf_pkg::COUNT_MAX
                                                 : mag[stf_pkg::COUNT_W-1:0];
          end else begin
            fan_nxt  = 1'b0;
            left_nxt = word[stf_pkg::COUNT_W-1:0];
          end
          wir_nxt     = '0;
          seen_nxt    = stf_pkg::SEEN_NONE;
          in_prim_nxt = 1'b1;
        end
      end else if (wir_r != stf_pkg::REC_LAST_WORD) begin
        wir_nxt = wir_r + 2'd1;
      end else begin
        wir_nxt = '0;
        case (seen_r)
          stf_pkg::SEEN_NONE: begin
            anchor_nxt = idx;
            seen_nxt   = stf_pkg::SEEN_ONE;
          end
          stf_pkg::SEEN_ONE: begin
            recent_nxt = idx;
            seen_nxt   = stf_pkg::SEEN_TWO;
          end
          default: begin
            res.emit         = 1'b1;
            res.data.index_a = anchor_r;
            res.data.index_b = recent_r;
            res.data.index_c = idx;
            if (!fan_r) begin
              anchor_nxt = recent_r;
            end
            recent_nxt = idx;
          end
        endcase
        left_nxt    = left_dec;
        in_prim_nxt = (left_dec != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_prim_r <= 1'b0;
      fan_r     <= 1'b0;
      left_r    <= '0;
      wir_r     <= '0;
      seen_r    <= stf_pkg::SEEN_NONE;
      anchor_r  <= '0;
      recent_r  <= '0;
    end else begin
      in_prim_r <= in_prim_nxt;
      fan_r     <= fan_nxt;
      left_r    <= left_nxt;
      wir_r     <= wir_nxt;
      seen_r    <= seen_nxt;
      anchor_r  <= anchor_nxt;
      recent_r  <= recent_nxt;
    end
  end

endmodule

@@ hw/rtl/stf_out_reg.sv @@
// Result register: holds one finished item until the sink takes it.
module stf_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  stf_pkg::res_t res,
  output logic          load_ok,
  stf_tri_if.source     out_ch
);

  logic          valid_r, valid_nxt;
  stf_pkg::tri_t tri_r, tri_nxt;

  always_comb begin
    load_ok   = !valid_r || out_ch.ready;
    valid_nxt = valid_r;
    tri_nxt   = tri_r;
    if (load_ok) begin
      valid_nxt = res.emit;
      tri_nxt   = res.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tri_r <= tri_nxt;
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.end_of_list = tri_r.end_of_list;
  assign out_ch.index_a     = tri_r.index_a;
  assign out_ch.index_b     = tri_r.index_b;
  assign out_ch.index_c     = tri_r.index_c;

endmodule

@@ hw/rtl/strip_fan_to_triangle_list.sv @@
// Top level of the strip/fan to triangle list converter.
// Takes one stream word per cycle: a command (zero ends the list, negative starts a fan,
// positive a strip, magnitude is the vertex count), then three-word vertex records whose
// third word is the index. Each vertex after the second gives one triangle on the result
// channel in the cycle after its index word is accepted; the terminator gives an end marker
// with zero indices. Input is taken every cycle while the result register is empty or
// being drained, so throughput is one word per cycle, set by the single result register.
module strip_fan_to_triangle_list (
  input logic       clk,
  input logic       rst_n,
  stf_word_if.sink  in_ch,
  stf_tri_if.source out_ch
);

  stf_pkg::res_t res;
  logic          load_ok;

  assign in_ch.ready = load_ok;

  stf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_ch.valid && load_ok),
    .word   (in_ch.word),
    .res    (res)
  );

  stf_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .res     (res),
    .load_ok (load_ok),
    .out_ch  (out_ch)
  );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the strip/fan to triangle list converter.
module tb_top;

  localparam int unsigned RANDOM_WORDS = 1020;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_PRINTS   = 50;

  // Tracks the parser state and holds the triangles due from the words taken so far.
  class triangle_checker;
    logic                        in_prim;
    logic                        fan;
    logic [stf_pkg::COUNT_W-1:0] verts_left;
    logic [1:0]                  rec_word;
    logic [1:0]                  seen;
    stf_pkg::idx_t               anchor;
    stf_pkg::idx_t               recent;
    stf_pkg::tri_t               triangles_due[$];
    int unsigned                 mismatches;
    int unsigned                 triangles;
    int unsigned                 markers;
    int unsigned                 fans;
    int unsigned                 strips;

    function new();
      in_prim    = 1'b0;
      fan        = 1'b0;
      verts_left = '0;
      rec_word   = '0;
      seen       = stf_pkg::SEEN_NONE;
      anchor     = '0;
      recent     = '0;
      mismatches = 0;
      triangles  = 0;
      markers    = 0;
      fans       = 0;
      strips     = 0;
    endfunction

    function logic busy();
      return in_prim;
    endfunction

    function int unsigned pending();
      return triangles_due.size();
    endfunction

    function void take_word(logic [stf_pkg::WORD_BITS-1:0] w);
      logic [stf_pkg::WORD_BITS-1:0] mag;
      logic [63:0]                   keep;
      stf_pkg::idx_t                 idx;
      stf_pkg::tri_t                 t;
      keep = (64'd1 << stf_pkg::INDEX_BITS) - 64'd1;
      t    = '0;
      if (!in_prim) begin
        if (w == '0) begin
          t.end_of_list = 1'b1;
          triangles_due.insert(triangles_due.size(), t);
        end else begin
          fan = w[stf_pkg::WORD_BITS-1];
          mag = fan ? -w : w;
          // most negative command saturates
          if (mag > {1'b0, stf_pkg::COUNT_MAX}) mag = {1'b0, stf_pkg::COUNT_MAX};
          verts_left = mag[stf_pkg::COUNT_W-1:0];
          rec_word   = '0;
          seen       = stf_pkg::SEEN_NONE;
          in_prim    = 1'b1;
          if (fan) fans++;
          else strips++;
        end
      end else if (rec_word != stf_pkg::REC_LAST_WORD) begin
        rec_word++;
      end else begin
        idx      = stf_pkg::idx_t'(64'(w) & keep);
        rec_word = '0;
        if (seen == stf_pkg::SEEN_NONE) begin
          anchor = idx;
          seen   = stf_pkg::SEEN_ONE;
        end else if (seen == stf_pkg::SEEN_ONE) begin
          recent = idx;
          seen   = stf_pkg::SEEN_TWO;
        end else begin
          t.index_a = anchor;
          t.index_b = recent;
          t.index_c = idx;
          triangles_due.insert(triangles_due.size(), t);
          if (!fan) anchor = recent;
          recent = idx;
        end
        if (verts_left != '0) verts_left--;
        if (verts_left == '0) in_prim = 1'b0;
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("MISMATCH: %s", msg);
    endtask

    task check_triangle(logic eol, stf_pkg::idx_t a, stf_pkg::idx_t b, stf_pkg::idx_t c);
      stf_pkg::tri_t want;
      int unsigned   n;
      n = triangles + markers + 1;
      if (triangles_due.size() == 0) begin
        report_mismatch($sformatf("item %0d not expected: eol %b %h %h %h", n, eol, a, b, c));
        return;
      end
      want = triangles_due.pop_front();
      if (eol !== want.end_of_list)
        report_mismatch($sformatf("item %0d end_of_list %b, want %b", n, eol, want.end_of_list));
      if (a !== want.index_a)
        report_mismatch($sformatf("item %0d index_a %h, want %h", n, a, want.index_a));
      if (b !== want.index_b)
        report_mismatch($sformatf("item %0d index_b %h, want %h", n, b, want.index_b));
      if (c !== want.index_c)
        report_mismatch($sformatf("item %0d index_c %h, want %h", n, c, want.index_c));
      if (want.end_of_list) markers++;
      else triangles++;
    endtask
  endclass

  logic clk;
  logic rst_n;

  stf_word_if in_ch ();
  stf_tri_if  out_ch ();

  strip_fan_to_triangle_list i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  triangle_checker               plan;
  triangle_checker               sb;
  logic [stf_pkg::WORD_BITS-1:0] stim_q[$];
  int unsigned                   words_in  = 0;
  int unsigned                   cycles    = 0;
  int unsigned                   pause_at  = 0;
  bit                            calm      = 1'b0;
  bit                            out_hold  = 1'b0;
  bit                            hold_done = 1'b0;

  task automatic push_word(logic [stf_pkg::WORD_BITS-1:0] w);
    stim_q.insert(stim_q.size(), w);
    plan.take_word(w);
  endtask

  function automatic logic [stf_pkg::WORD_BITS-1:0] pick_index();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($urandom_range(0, 15));
      2: return 32'($urandom_range(0, 65535));
      3: return {16'($urandom), 16'hFFFF};
      default: return 32'($urandom_range(65500, 65535));
    endcase
  endfunction

  task automatic add_record(logic [stf_pkg::WORD_BITS-1:0] idx_word);
    push_word($urandom);
    push_word($urandom);
    push_word(idx_word);
  endtask

  task automatic add_primitive(bit fan_cmd, int unsigned n);
    push_word(fan_cmd ? -32'(n) : 32'(n));
    repeat (n) add_record(pick_index());
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_triangle(out_ch.end_of_list, out_ch.index_a, out_ch.index_b, out_ch.index_c);
      if (in_ch.valid && in_ch.ready) begin
        sb.take_word(in_ch.word);
        words_in++;
      end
    end
  end

  // Result side: random stalls, one long hold-off, then always ready.
  initial begin
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (calm) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else if (!hold_done && words_in >= HOLD_AT) begin
        out_hold = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold  = 1'b0;
        hold_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned k;
    int unsigned kind;
    int unsigned target;
    int unsigned calm_from;
    plan = new();
    sb   = new();
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.word   <= '0;

    // directed: terminator, a strip, a fan, a single-vertex primitive, terminator
    push_word('0);
    push_word(32'd3);
    push_word(32'h8000_0000); push_word(32'h7FFF_FFFF); push_word(32'h0000_FFFF);
    push_word(32'hFFFF_FFFF); push_word(32'h0000_0000); push_word(32'hFFFF_0000);
    push_word(32'h5555_5555); push_word(32'hAAAA_AAAA); push_word(32'hABCD_1234);
    push_word(32'hFFFF_FFFD);
    push_word(32'h0000_0000); push_word(32'h0000_0000); push_word(32'h0000_0001);
    push_word(32'h0000_0001); push_word(32'h0000_0002); push_word(32'h7FFF_FFFF);
    push_word(32'h0F0F_0F0F); push_word(32'hF0F0_F0F0); push_word(32'h8000_0005);
    push_word(32'd1);
    add_record(32'h0000_0042);
    push_word('0);

    target = stim_q.size() + RANDOM_WORDS;
    while (stim_q.size() < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        push_word('0);
      end else if (kind < 88) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        add_primitive($urandom_range(0, 1), n);
      end else begin
        // broken primitive: too few, just enough or too many words, then pad back to a command
        n = $urandom_range(1, 6);
        push_word($urandom_range(0, 1) ? -32'(n) : 32'(n));
        k = 3 * n + $urandom_range(0, 4) - 2;
        repeat (k) push_word(32'($urandom_range(0, 12)) - 32'd6);
        while (plan.busy()) push_word(pick_index());
      end
    end
    // most negative command last: its count does not run out in this test
    push_word(32'h8000_0000);
    repeat (20) add_record(pick_index());

    pause_at  = stim_q.size() / 2;
    calm_from = stim_q.size() * 85 / 100;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < stim_q.size(); i++) begin
      if (i == pause_at) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      if (i >= calm_from) calm = 1'b1;
      if (!calm && !out_hold && $urandom_range(0, 5) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.word  <= stim_q[i];
      do @(posedge clk); while (!in_ch.ready);
    end
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d words, %0d fans and %0d strips, %0d triangles and %0d end markers",
             words_in, sb.fans, sb.strips, sb.triangles, sb.markers);
    $display("Summary: result side held off %0d cycles once, input drained at word %0d",
             HOLD_CYCLES, pause_at);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
